// File: rtl/chbd_pkg.sv
// Package for the HTTP chunked body decoder.
// Holds phase and status codes, character constants, the result record and
// the hex digit decoder; no dependencies.
package chbd_pkg;

  localparam int unsigned SizeBitsDef  = 32;
  localparam int unsigned CountBitsDef = 16;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned SmallW = 16;
  localparam int unsigned WideW  = 32;

  localparam logic [ByteW-1:0] ChCr  = 8'h0D;
  localparam logic [ByteW-1:0] ChLf  = 8'h0A;
  localparam logic [ByteW-1:0] ChSp  = 8'h20;
  localparam logic [ByteW-1:0] ChTab = 8'h09;

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_SIZE  = 3'd1,
    PH_BODY  = 3'd2,
    PH_SKIP  = 3'd3,
    PH_TRAIL = 3'd4,
    PH_DONE  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SAT     = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0]  body_byte;
    logic              body_valid;
    logic              last_of_chunk;
    logic              message_done;
    status_e           status;
    logic [SmallW-1:0] chunk_count;
    logic [WideW-1:0]  body_total;
    logic [WideW-1:0]  wire_total;
    logic [SmallW-1:0] trailer_length;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_value(input logic [ByteW-1:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.nib = 4'd0;
    if (b >= "0" && b <= "9") begin
      h.nib = 4'(b - "0");
    end else if (b >= "a" && b <= "f") begin
      h.nib = 4'(b - "a" + 8'd10);
    end else if (b >= "A" && b <= "F") begin
      h.nib = 4'(b - "A" + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// File: rtl/chbd_core.sv
// Decoder state and per-byte update for the chunked body decoder.
// Updates the state on each fired transaction (none once the message is done,
// but for a restart) and forms its result. Depends on chbd_pkg.
module chbd_core #(
  parameter int unsigned SIZE_BITS  = chbd_pkg::SizeBitsDef,
  parameter int unsigned COUNT_BITS = chbd_pkg::CountBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic                       mode_i,
  input  logic [chbd_pkg::ByteW-1:0] byte_i,
  output chbd_pkg::result_t          res_o
);

  chbd_pkg::phase_e            phase_q, phase_d;
  logic [SIZE_BITS-1:0]        size_q, size_d;
  logic                        closed_q, closed_d;
  logic                        saw_cr_q, saw_cr_d;
  logic [SIZE_BITS-1:0]        remain_q, remain_d;
  logic [1:0]                  skip_q, skip_d;
  logic [2:0]                  pm_q, pm_d;
  logic [COUNT_BITS-1:0]       chunks_q, chunks_d;
  logic [chbd_pkg::WideW-1:0]  body_q, body_d;
  logic [chbd_pkg::WideW-1:0]  wire_q, wire_d;
  logic [COUNT_BITS-1:0]       trail_q, trail_d;

  chbd_pkg::hex_t              hex;
  logic [SIZE_BITS-1:0]        remain_dec;
  logic [2:0]                  pm_next;
  logic [chbd_pkg::ByteW-1:0]  pat_byte;
  logic                        done;

  assign hex = chbd_pkg::hex_value(byte_i);

  always_comb begin
    phase_d  = phase_q;
    size_d   = size_q;
    closed_d = closed_q;
    saw_cr_d = saw_cr_q;
    remain_d = remain_q;
    skip_d   = skip_q;
    pm_d     = pm_q;
    chunks_d = chunks_q;
    body_d   = body_q;
    wire_d   = wire_q;
    trail_d  = trail_q;
    res_o    = '0;
    res_o.status = chbd_pkg::ST_OK;
    remain_dec = '0;
    pm_next  = '0;
    pat_byte = chbd_pkg::ChCr;
    done     = 1'b0;

    if (fire_i) begin
      if (mode_i) begin
        phase_d  = chbd_pkg::PH_LEAD;
        size_d   = '0;
        closed_d = 1'b0;
        saw_cr_d = 1'b0;
        remain_d = '0;
        skip_d   = '0;
        pm_d     = '0;
        chunks_d = '0;
        body_d   = '0;
        wire_d   = '0;
        trail_d  = '0;
      end else if (phase_q == chbd_pkg::PH_DONE) begin
        res_o.status = chbd_pkg::ST_IGNORED;
      end else begin
        if (wire_q != '1) wire_d = wire_q + 1'b1;
        unique case (phase_q)
          chbd_pkg::PH_LEAD, chbd_pkg::PH_SIZE: begin
            if (saw_cr_q && byte_i == chbd_pkg::ChLf) begin
              if (chunks_q != '1) chunks_d = chunks_q + 1'b1;
              if (size_q == '0) begin
                phase_d = chbd_pkg::PH_TRAIL;
                pm_d    = '0;
                trail_d = '0;
              end else begin
                phase_d  = chbd_pkg::PH_BODY;
                remain_d = size_q;
              end
            end else begin
              if (!(phase_q == chbd_pkg::PH_LEAD &&
                    (byte_i == chbd_pkg::ChSp || byte_i == chbd_pkg::ChTab))) begin
                phase_d = chbd_pkg::PH_SIZE;
                if (!closed_q && hex.ok) begin
                  if (|size_q[SIZE_BITS-1 -: 4]) begin
                    size_d       = '1;
                    res_o.status = chbd_pkg::ST_SAT;
                  end else begin
                    size_d = {size_q[SIZE_BITS-5:0], hex.nib};
                  end
                end else begin
                  closed_d = 1'b1;
                end
              end
              saw_cr_d = (byte_i == chbd_pkg::ChCr);
            end
          end
          chbd_pkg::PH_BODY: begin
            res_o.body_valid = 1'b1;
            res_o.body_byte  = byte_i;
            if (body_q != '1) body_d = body_q + 1'b1;
            remain_dec = (remain_q != '0) ? remain_q - 1'b1 : remain_q;
            remain_d   = remain_dec;
            if (remain_dec == '0) begin
              res_o.last_of_chunk = 1'b1;
              phase_d = chbd_pkg::PH_SKIP;
              skip_d  = 2'd2;
            end
          end
          chbd_pkg::PH_SKIP: begin
            skip_d = (skip_q != '0) ? skip_q - 1'b1 : skip_q;
            if (skip_d == '0) begin
              phase_d  = chbd_pkg::PH_LEAD;
              size_d   = '0;
              closed_d = 1'b0;
              saw_cr_d = 1'b0;
            end
          end
          chbd_pkg::PH_TRAIL: begin
            if (trail_q != '1) trail_d = trail_q + 1'b1;
            if (trail_q == COUNT_BITS'(1) && pm_q == 3'd1 && byte_i == chbd_pkg::ChLf) begin
              done = 1'b1;
            end else begin
              pat_byte = pm_q[0] ? chbd_pkg::ChLf : chbd_pkg::ChCr;
              if (byte_i == pat_byte) pm_next = pm_q + 1'b1;
              else pm_next = (byte_i == chbd_pkg::ChCr) ? 3'd1 : 3'd0;
              pm_d = pm_next;
              if (pm_next >= 3'd4) done = 1'b1;
            end
            if (done) begin
              phase_d = chbd_pkg::PH_DONE;
              pm_d    = '0;
            end
            res_o.message_done = done;
          end
          default: begin
          end
        endcase
      end
    end

    res_o.chunk_count    = chbd_pkg::SmallW'(chunks_d);
    res_o.body_total     = body_d;
    res_o.wire_total     = wire_d;
    res_o.trailer_length = chbd_pkg::SmallW'(trail_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= chbd_pkg::PH_LEAD;
      size_q   <= '0;
      closed_q <= 1'b0;
      saw_cr_q <= 1'b0;
      remain_q <= '0;
      skip_q   <= '0;
      pm_q     <= '0;
      chunks_q <= '0;
      body_q   <= '0;
      wire_q   <= '0;
      trail_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      size_q   <= size_d;
      closed_q <= closed_d;
      saw_cr_q <= saw_cr_d;
      remain_q <= remain_d;
      skip_q   <= skip_d;
      pm_q     <= pm_d;
      chunks_q <= chunks_d;
      body_q   <= body_d;
      wire_q   <= wire_d;
      trail_q  <= trail_d;
    end
  end

endmodule

// File: rtl/http_chunked_body_decoder.sv
// HTTP chunked body decoder, top level.
// Input and result registers around chbd_core; depends on chbd_pkg.
//
// Usage:
//   Slave stream: one byte of the chunked message per transaction. tdata
//   carries the byte, tuser[0] set means restart (all state and counters
//   cleared, result all zeros).
//   Master stream: one result per input transaction, in order. tdata holds
//   the body byte and the four running counters, tuser the flags and
//   status, tlast marks the final body byte of a chunk.
//   Result path: the input transaction is held in the input register, then
//   the state update is written into the result register.
//   Throughput: one byte per cycle while the result register is empty or
//   taken; the per-byte state update between the two registers is combinational.
//   Stall: while the result register is full and not taken, the input
//   register holds one more byte, then tready drops; nothing is lost.
//   Reset: decoder returns to the start of a size line, counters zero,
//   both registers empty.
module http_chunked_body_decoder #(
  parameter int unsigned SIZE_BITS  = chbd_pkg::SizeBitsDef,
  parameter int unsigned COUNT_BITS = chbd_pkg::CountBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] data_byte
  input  logic [7:0]    s_axis_tuser,   // [0] mode, [7:1] zero
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [103:0]  m_axis_tdata,   // [7:0] body_byte, [23:8] chunk_count,
                                        // [55:24] body_total, [87:56] wire_total,
                                        // [103:88] trailer_length
  output logic [7:0]    m_axis_tuser,   // [0] body_valid, [1] message_done,
                                        // [3:2] status, [7:4] zero
  output logic          m_axis_tlast    // last_of_chunk
);

  logic                       in_valid_q;
  logic                       in_mode_q;
  logic [chbd_pkg::ByteW-1:0] in_byte_q;
  logic                       out_valid_q;
  chbd_pkg::result_t          res;
  chbd_pkg::result_t          out_q;
  logic                       fire;
  logic                       s_accept;

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_accept) in_valid_q <= 1'b1;
      else if (fire) in_valid_q <= 1'b0;
      if (fire) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_mode_q <= s_axis_tuser[0];
      in_byte_q <= s_axis_tdata;
    end
    if (fire) out_q <= res;
  end

  chbd_core #(
    .SIZE_BITS  (SIZE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .mode_i (in_mode_q),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.trailer_length, out_q.wire_total, out_q.body_total,
                          out_q.chunk_count, out_q.body_byte};
  assign m_axis_tuser  = {4'd0, out_q.status, out_q.message_done, out_q.body_valid};
  assign m_axis_tlast  = out_q.last_of_chunk;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for http_chunked_body_decoder: directed and random chunked messages
// go in on the slave stream, every result is checked against a local byte decoder.
// Depends on chbd_pkg and the decoder RTL.
module testbench;

  localparam logic [63:0] SizeMax       = 64'hFFFF_FFFF;
  localparam logic [15:0] CountMax      = 16'hFFFF;
  localparam logic [31:0] WideMax       = 32'hFFFF_FFFF;
  localparam int unsigned ItemsPerRound = 250;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned ReportMax     = 10;

  typedef struct packed {
    logic       restart;
    logic [7:0] data;
  } wire_item_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata  = '0;   // [7:0] data_byte
  logic [7:0]   s_axis_tuser  = '0;   // [0] mode, [7:1] zero
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;         // [7:0] body_byte, [23:8] chunk_count,
                                      // [55:24] body_total, [87:56] wire_total,
                                      // [103:88] trailer_length
  logic [7:0]   m_axis_tuser;         // [0] body_valid, [1] message_done, [3:2] status
  logic         m_axis_tlast;         // last_of_chunk

  http_chunked_body_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  wire_item_t         tx_items[$];
  chbd_pkg::result_t  awaited[$];
  logic [7:0]         msg[$];
  wire_item_t         tx_head;
  chbd_pkg::result_t  got, want;

  int unsigned send_idle = 33;
  int unsigned recv_idle = 57;
  int unsigned items_queued, items_sent, results_seen, mismatches;
  int unsigned msgs_done, sat_hits, body_seen;
  int unsigned quiet;

  // decoder state
  chbd_pkg::phase_e dec_phase;
  logic [63:0] size_acc;
  logic        digits_done, cr_pending;
  logic [63:0] body_left;
  int unsigned skip_left, match_len;
  logic [15:0] chunks;
  logic [31:0] body_cnt, wire_cnt;
  logic [15:0] trail_len;

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
    return -1;
  endfunction

  function automatic void begin_size_line();
    dec_phase   = chbd_pkg::PH_LEAD;
    size_acc    = '0;
    digits_done = 1'b0;
    cr_pending  = 1'b0;
  endfunction

  function automatic void clear_decoder();
    begin_size_line();
    body_left = '0;
    skip_left = 0;
    match_len = 0;
    chunks    = '0;
    body_cnt  = '0;
    wire_cnt  = '0;
    trail_len = '0;
  endfunction

  function automatic chbd_pkg::result_t decode_byte(input logic restart,
                                                    input logic [7:0] b);
    chbd_pkg::result_t r;
    int          nib;
    logic [63:0] grown;
    logic [7:0]  pat;
    logic        second, first_cr;
    r = '0;
    r.status = chbd_pkg::ST_OK;
    if (restart) begin
      clear_decoder();
    end else if (dec_phase == chbd_pkg::PH_DONE) begin
      r.status = chbd_pkg::ST_IGNORED;
    end else begin
      if (wire_cnt != WideMax) wire_cnt = wire_cnt + 1;
      case (dec_phase)
        chbd_pkg::PH_LEAD, chbd_pkg::PH_SIZE: begin
          if (cr_pending && b == chbd_pkg::ChLf) begin
            if (chunks != CountMax) chunks = chunks + 16'd1;
            if (size_acc == 0) begin
              dec_phase = chbd_pkg::PH_TRAIL;
              match_len = 0;
              trail_len = '0;
            end else begin
              dec_phase = chbd_pkg::PH_BODY;
              body_left = size_acc;
            end
          end else begin
            nib = nibble_of(b);
            if (!(dec_phase == chbd_pkg::PH_LEAD &&
                  (b == chbd_pkg::ChSp || b == chbd_pkg::ChTab))) begin
              dec_phase = chbd_pkg::PH_SIZE;
              if (!digits_done && nib >= 0) begin
                grown = (size_acc << 4) | 64'(nib);
                if (size_acc > (SizeMax >> 4) || grown > SizeMax) begin
                  size_acc = SizeMax;
                  r.status = chbd_pkg::ST_SAT;
                end else begin
                  size_acc = grown;
                end
              end else begin
                digits_done = 1'b1;
              end
            end
            cr_pending = (b == chbd_pkg::ChCr);
          end
        end
        chbd_pkg::PH_BODY: begin
          r.body_valid = 1'b1;
          r.body_byte  = b;
          if (body_cnt != WideMax) body_cnt = body_cnt + 1;
          if (body_left > 0) body_left = body_left - 1;
          if (body_left == 0) begin
            r.last_of_chunk = 1'b1;
            dec_phase = chbd_pkg::PH_SKIP;
            skip_left = 2;
          end
        end
        chbd_pkg::PH_SKIP: begin
          if (skip_left > 0) skip_left = skip_left - 1;
          if (skip_left == 0) begin_size_line();
        end
        default: begin
          second   = (trail_len == 16'd1);
          first_cr = (match_len == 1);
          if (trail_len != CountMax) trail_len = trail_len + 16'd1;
          if (second && first_cr && b == chbd_pkg::ChLf) begin
            r.message_done = 1'b1;
          end else begin
            // looking for CR LF CR LF
            pat = match_len[0] ? chbd_pkg::ChLf : chbd_pkg::ChCr;
            if (b == pat) match_len = match_len + 1;
            else match_len = (b == chbd_pkg::ChCr) ? 1 : 0;
            if (match_len >= 4) r.message_done = 1'b1;
          end
          if (r.message_done) begin
            dec_phase = chbd_pkg::PH_DONE;
            match_len = 0;
          end
        end
      endcase
    end
    r.chunk_count    = chunks;
    r.body_total     = body_cnt;
    r.wire_total     = wire_cnt;
    r.trailer_length = trail_len;
    return r;
  endfunction

  task automatic push_item(input logic restart, input logic [7:0] b);
    wire_item_t it;
    it.restart = restart;
    it.data    = b;
    tx_items.push_back(it);
    items_queued++;
  endtask

  task automatic flush_msg();
    foreach (msg[i]) push_item(1'b0, msg[i]);
    msg.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
  endtask

  task automatic add_crlf();
    msg.push_back(chbd_pkg::ChCr);
    msg.push_back(chbd_pkg::ChLf);
  endtask

  task automatic add_size_line(input logic [63:0] size, input bit close);
    string      digits;
    logic [7:0] c;
    repeat ($urandom_range(2))
      msg.push_back($urandom_range(1) ? chbd_pkg::ChSp : chbd_pkg::ChTab);
    repeat ($urandom_range(1)) add_text("0");
    digits = $sformatf("%0h", size);
    for (int i = 0; i < digits.len(); i++) begin
      c = digits[i];
      if (c >= 8'h61 && $urandom_range(1)) c = c - 8'd32;
      msg.push_back(c);
    end
    if (close) begin
      if ($urandom_range(3) == 0) begin
        add_text(";n=");
        repeat ($urandom_range(3)) msg.push_back(8'($urandom_range(126, 33)));
        if ($urandom_range(2) == 0) begin
          msg.push_back(chbd_pkg::ChCr);
          add_text("z");
        end
      end
      add_crlf();
    end
  endtask

  task automatic gen_message();
    int unsigned n, len;
    logic [63:0] big;
    msg.delete();
    n = $urandom_range(3);
    for (int k = 0; k < n; k++) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      add_size_line(64'(len), 1'b1);
      for (int i = 0; i < len; i++)
        msg.push_back($urandom_range(1) ? 8'($urandom) : 8'($urandom_range(126, 32)));
      if ($urandom_range(4) == 0) begin
        msg.push_back(8'($urandom));
        msg.push_back(8'($urandom));
      end else begin
        add_crlf();
      end
    end
    if ($urandom_range(19) == 0) begin
      // oversized count, left unterminated
      big = {$urandom_range(32'hFFFF, 1), $urandom};
      add_size_line(big, 1'b0);
    end else begin
      repeat ($urandom_range(1)) msg.push_back(chbd_pkg::ChSp);
      case ($urandom_range(3))
        0:       add_text("0");
        1:       add_text("000");
        2:       add_text("0x1F");
        default: add_text("-7");
      endcase
      add_crlf();
      if ($urandom_range(1)) begin
        add_crlf();
      end else begin
        repeat ($urandom_range(2, 1)) begin
          add_text("X-");
          repeat ($urandom_range(4, 1)) msg.push_back(8'($urandom_range(122, 97)));
          add_text(": ");
          repeat ($urandom_range(4)) msg.push_back(8'($urandom_range(126, 32)));
          if ($urandom_range(3) == 0) begin
            msg.push_back(chbd_pkg::ChCr);
            add_text("q");
          end
          add_crlf();
        end
        add_crlf();
      end
      repeat ($urandom_range(2)) msg.push_back(8'($urandom));
    end
  endtask

  task automatic ship_message();
    int unsigned sel, cut;
    sel = $urandom_range(9);
    push_item(1'b1, 8'($urandom));
    if (sel == 0) begin
      msg.delete();
      repeat ($urandom_range(20, 4)) msg.push_back(8'($urandom));
    end else if (sel == 1 && msg.size() > 1) begin
      msg[$urandom_range(msg.size() - 1)] = 8'($urandom);
    end else if (sel == 2 && msg.size() > 1) begin
      cut = $urandom_range(msg.size() - 1, 1);
      while (msg.size() > cut) void'(msg.pop_back());
    end
    flush_msg();
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (tx_items.size() != 0 || s_axis_tvalid || awaited.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= ReportMax)
        $display("mismatch, result %0d, %s: expected %0h, got %0h",
                 results_seen, name, want_v, got_v);
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        awaited.push_back(decode_byte(s_axis_tuser[0], s_axis_tdata));
        items_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_items.size() != 0 && $urandom_range(99) >= send_idle) begin
          tx_head = tx_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= tx_head.data;
          s_axis_tuser  <= {7'd0, tx_head.restart};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.body_byte      = m_axis_tdata[7:0];
      got.chunk_count    = m_axis_tdata[23:8];
      got.body_total     = m_axis_tdata[55:24];
      got.wire_total     = m_axis_tdata[87:56];
      got.trailer_length = m_axis_tdata[103:88];
      got.body_valid     = m_axis_tuser[0];
      got.message_done   = m_axis_tuser[1];
      got.status         = chbd_pkg::status_e'(m_axis_tuser[3:2]);
      got.last_of_chunk  = m_axis_tlast;
      results_seen++;
      if (got.message_done) msgs_done++;
      if (got.status == chbd_pkg::ST_SAT) sat_hits++;
      if (got.body_valid) body_seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("mismatch, result %0d arrived with nothing outstanding", results_seen);
      end else begin
        want = awaited.pop_front();
        check_field("body_byte", 32'(want.body_byte), 32'(got.body_byte));
        check_field("body_valid", 32'(want.body_valid), 32'(got.body_valid));
        check_field("last_of_chunk", 32'(want.last_of_chunk), 32'(got.last_of_chunk));
        check_field("message_done", 32'(want.message_done), 32'(got.message_done));
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("chunk_count", 32'(want.chunk_count), 32'(got.chunk_count));
        check_field("body_total", want.body_total, got.body_total);
        check_field("wire_total", want.wire_total, got.wire_total);
        check_field("trailer_length", 32'(want.trailer_length), 32'(got.trailer_length));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet >= StallLimit) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               quiet, awaited.size());
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int unsigned target;
    clear_decoder();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: blanks, lone CR, extreme body bytes, empty trailer, byte after end
    push_item(1'b1, 8'($urandom));
    msg.push_back(chbd_pkg::ChSp);
    msg.push_back(chbd_pkg::ChTab);
    add_text("2");
    msg.push_back(chbd_pkg::ChCr);
    add_text(";");
    add_crlf();
    msg.push_back(8'h00);
    msg.push_back(8'hFF);
    add_crlf();
    add_text("0");
    add_crlf();
    add_crlf();
    msg.push_back(8'h5A);
    flush_msg();
    // size overflow, then a digit on an already saturated size
    push_item(1'b1, 8'hFF);
    add_text("FFFFFFFFF1");
    flush_msg();

    for (int round = 0; round < 3; round++) begin
      case (round)
        0: begin
          send_idle = 33;
          recv_idle = 57;
        end
        1: begin
          send_idle = 57;
          recv_idle = 33;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      target = items_queued + ItemsPerRound;
      while (items_queued < target) begin
        gen_message();
        ship_message();
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    mismatches += awaited.size();
    $display("run: %0d bytes and restarts sent, %0d results checked, %0d mismatches",
             items_sent, results_seen, mismatches);
    $display("run: %0d messages completed, %0d body bytes, %0d saturated size digits",
             msgs_done, body_seen, sat_hits);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/chbd_pkg.sv
rtl/chbd_core.sv
rtl/http_chunked_body_decoder.sv
verif/testbench.sv
